/* sv/fl2_pkg.sv */
// Shared constants and single-precision arithmetic helpers for the log2 approximation.
`default_nettype none

package fl2_pkg;

	localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
	localparam logic [31:0] COEF_C0   = 32'h4012_21A2;
	localparam logic [31:0] COEF_C1   = 32'hBF86_49E9;
	localparam logic [31:0] COEF_C2   = 32'h3E51_5A4B;
	localparam logic [7:0]  EXP_BIAS  = 8'd127;
	localparam int          MANT_W    = 23;
	localparam int          SIDE_W    = 96;

	// Multiply of normal or zero operands, round to nearest even.
	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic [23:0]       ma;
		logic [23:0]       mb;
		logic [47:0]       prod;
		logic signed [9:0] ex;
		logic [22:0]       mant;
		logic              g;
		logic              st;
		logic [24:0]       r;
		logic              sgn;
		sgn = a[31] ^ b[31];
		ma = {1'b1, a[22:0]};
		mb = {1'b1, b[22:0]};
		prod = ma * mb;
		ex = $signed({2'b00, a[30:23]}) + $signed({2'b00, b[30:23]}) - 10'sd127;
		if (prod[47]) begin
			mant = prod[46:24];
			g = prod[23];
			st = |prod[22:0];
			ex = ex + 10'sd1;
		end else begin
			mant = prod[45:23];
			g = prod[22];
			st = |prod[21:0];
		end
		r = {2'b01, mant} + {24'd0, g & (st | mant[0])};
		if (r[24]) begin
			ex = ex + 10'sd1;
			mant = '0;
		end else begin
			mant = r[22:0];
		end
		if (a[30:23] == 8'd0 || b[30:23] == 8'd0) begin
			return {sgn, 31'd0};
		end
		return {sgn, ex[7:0], mant};
	endfunction

	// Add of normal or zero operands, round to nearest even.
	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0]       big;
		logic [31:0]       sml;
		logic [7:0]        d;
		logic [4:0]        sh;
		logic [26:0]       mb;
		logic [26:0]       ms;
		logic [53:0]       w;
		logic [26:0]       ms_al;
		logic [27:0]       sum;
		logic [26:0]       n;
		logic [4:0]        p;
		logic [4:0]        lz;
		logic signed [9:0] ex;
		logic [24:0]       r;
		logic [22:0]       frac;
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		d = big[30:23] - sml[30:23];
		sh = (d > 8'd27) ? 5'd27 : d[4:0];
		mb = {1'b1, big[22:0], 3'b000};
		ms = {1'b1, sml[22:0], 3'b000};
		w = {ms, 27'd0} >> sh;
		ms_al = {w[53:28], w[27] | (|w[26:0])};
		if (big[31] ^ sml[31]) begin
			sum = {1'b0, mb} - {1'b0, ms_al};
		end else begin
			sum = {1'b0, mb} + {1'b0, ms_al};
		end
		ex = $signed({2'b00, big[30:23]});
		p = '0;
		for (int i = 0; i < 27; i++) begin
			if (sum[i]) p = 5'(i);
		end
		if (sum[27]) begin
			n = {sum[27:2], sum[1] | sum[0]};
			ex = ex + 10'sd1;
		end else begin
			lz = 5'd26 - p;
			n = sum[26:0] << lz;
			ex = ex - $signed({5'd0, lz});
		end
		r = {1'b0, n[26:3]} + {24'd0, n[2] & ((|n[1:0]) | n[3])};
		if (r[24]) begin
			ex = ex + 10'sd1;
			frac = '0;
		end else begin
			frac = r[22:0];
		end
		if (sml[30:23] == 8'd0) begin
			return big;
		end
		if (sum == 28'd0) begin
			return 32'd0;
		end
		return {big[31], ex[7:0], frac};
	endfunction

endpackage

`default_nettype wire

/* sv/fl2_mul_stage.sv */
// One pipeline stage holding a registered single-precision multiply.
`default_nettype none

module fl2_mul_stage import fl2_pkg::*; #(
	parameter int TAG_W = 96
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	output logic                  up_stall,
	input  wire logic [31:0]      a,
	input  wire logic [31:0]      b,
	input  wire logic [TAG_W-1:0] tag,
	output logic                  dn_valid,
	input  wire logic             dn_stall,
	output logic [31:0]           res,
	output logic [TAG_W-1:0]      res_tag
);

	logic             valid_s1;
	logic [31:0]      res_s1;
	logic [TAG_W-1:0] tag_s1;

	assign up_stall = valid_s1 & dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			res_s1 <= fp_mul(a, b);
			tag_s1 <= tag;
		end
	end

	assign dn_valid = valid_s1;
	assign res      = res_s1;
	assign res_tag  = tag_s1;

endmodule

`default_nettype wire

/* sv/fl2_add_stage.sv */
// One pipeline stage holding a registered single-precision add.
`default_nettype none

module fl2_add_stage import fl2_pkg::*; #(
	parameter int TAG_W = 96
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             up_valid,
	output logic                  up_stall,
	input  wire logic [31:0]      a,
	input  wire logic [31:0]      b,
	input  wire logic [TAG_W-1:0] tag,
	output logic                  dn_valid,
	input  wire logic             dn_stall,
	output logic [31:0]           res,
	output logic [TAG_W-1:0]      res_tag
);

	logic             valid_s1;
	logic [31:0]      res_s1;
	logic [TAG_W-1:0] tag_s1;

	assign up_stall = valid_s1 & dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			res_s1 <= fp_add(a, b);
			tag_s1 <= tag;
		end
	end

	assign dn_valid = valid_s1;
	assign res      = res_s1;
	assign res_tag  = tag_s1;

endmodule

`default_nettype wire

/* sv/float_log2_approx.sv */
// Top level: six-stage pipelined approximate log2 of a single-precision word.
// Usage:
//   Input beat: x_bits with x_valid; taken on a clock edge where x_valid is
//   high and x_stall is low. Sign is ignored; zero, denormal, inf and NaN
//   take the same arithmetic path and give finite results.
//   Output beat: log2_bits with log2_valid; the receiver holds log2_stall
//   high to keep the beat in place.
//   Each float multiply or add of the Horner chain sits in its own
//   registered stage between input beat and output beat.
//   Throughput is one beat per cycle while log2_stall is low. A stage
//   moves whenever it is empty or the stage after it moves, so bubbles
//   fill up under stall and no beat is lost or repeated; x_stall rises
//   only once every stage holds a beat and log2_stall is high.
//   Reset (arst_n low) empties the pipeline; no beat is pending after it.
`default_nettype none

module float_log2_approx import fl2_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        x_valid,
	output logic             x_stall,
	input  wire logic [31:0] x_bits,
	output logic             log2_valid,
	input  wire logic        log2_stall,
	output logic [31:0]      log2_bits
);

	logic [31:0] m_in;
	logic [31:0] f_in;
	logic [31:0] e_in;
	logic [22:0] mant;
	logic [8:0]  ev;
	logic [7:0]  emag;
	logic [2:0]  ep;
	logic [4:0]  fp;
	logic [45:0] fsh;
	logic [30:0] esh;

	// m, m-1 and the unbiased exponent are all exact conversions
	always_comb begin
		mant = x_bits[MANT_W-1:0];
		m_in = {ONE_BITS[31:23], mant};
		fp = '0;
		for (int i = 0; i < 23; i++) begin
			if (mant[i]) fp = 5'(i);
		end
		fsh = {23'd0, mant} << (5'd23 - fp);
		if (mant == '0) f_in = 32'd0;
		else f_in = {1'b0, 8'd104 + {3'd0, fp}, fsh[22:0]};
		ev = {1'b0, x_bits[30:23]} - {1'b0, EXP_BIAS};
		emag = ev[8] ? 8'(-ev) : ev[7:0];
		ep = '0;
		for (int i = 0; i < 8; i++) begin
			if (emag[i]) ep = 3'(i);
		end
		esh = {23'd0, emag} << (5'd23 - {2'd0, ep});
		if (emag == '0) e_in = 32'd0;
		else e_in = {ev[8], 8'd127 + {5'd0, ep}, esh[22:0]};
	end

	logic [5:0]        v;
	logic [5:0]        st;
	logic [31:0]       r1, r2, r3, r4, r5;
	logic [SIDE_W-1:0] t1, t2;
	logic [63:0]       t3, t4;
	logic [31:0]       t5;

	fl2_mul_stage #(.TAG_W(SIDE_W)) u_c2m (
		.clk, .arst_n,
		.up_valid(x_valid), .up_stall(st[0]),
		.a(COEF_C2), .b(m_in), .tag({m_in, f_in, e_in}),
		.dn_valid(v[0]), .dn_stall(st[1]), .res(r1), .res_tag(t1)
	);

	fl2_add_stage #(.TAG_W(SIDE_W)) u_c1 (
		.clk, .arst_n,
		.up_valid(v[0]), .up_stall(st[1]),
		.a(r1), .b(COEF_C1), .tag(t1),
		.dn_valid(v[1]), .dn_stall(st[2]), .res(r2), .res_tag(t2)
	);

	// m is no longer needed past this stage
	fl2_mul_stage #(.TAG_W(64)) u_pm (
		.clk, .arst_n,
		.up_valid(v[1]), .up_stall(st[2]),
		.a(r2), .b(t2[95:64]), .tag(t2[63:0]),
		.dn_valid(v[2]), .dn_stall(st[3]), .res(r3), .res_tag(t3)
	);

	fl2_add_stage #(.TAG_W(64)) u_c0 (
		.clk, .arst_n,
		.up_valid(v[2]), .up_stall(st[3]),
		.a(r3), .b(COEF_C0), .tag(t3),
		.dn_valid(v[3]), .dn_stall(st[4]), .res(r4), .res_tag(t4)
	);

	fl2_mul_stage #(.TAG_W(32)) u_pf (
		.clk, .arst_n,
		.up_valid(v[3]), .up_stall(st[4]),
		.a(r4), .b(t4[63:32]), .tag(t4[31:0]),
		.dn_valid(v[4]), .dn_stall(st[5]), .res(r5), .res_tag(t5)
	);

	fl2_add_stage #(.TAG_W(1)) u_pe (
		.clk, .arst_n,
		.up_valid(v[4]), .up_stall(st[5]),
		.a(r5), .b(t5), .tag(1'b0),
		.dn_valid(v[5]), .dn_stall(log2_stall), .res(log2_bits), .res_tag()
	);

	assign x_stall    = st[0];
	assign log2_valid = v[5];

endmodule

`default_nettype wire
